// ===== rtl/pcr_pkg.sv =====
// pcr_pkg: shared types, widths and the saturation helper for the contact resolver
// used by particle_contact_resolve and its bench; depends on nothing
package pcr_pkg;

  localparam int IN_TDATA_W  = 344;
  localparam int OUT_TDATA_W = 224;
  localparam int OUT_TUSER_W = 2;
  localparam int REST_W      = 17;
  localparam int NRM_W       = 18;
  localparam int VEL_W       = 32;
  localparam int PEN_W       = 31;
  localparam int DOT_W       = 52;
  localparam int MAG_W       = 51;
  localparam int SAT_W       = 72;

  localparam logic PART_A = 1'b0;
  localparam logic PART_B = 1'b1;

  typedef struct packed {
    logic [PEN_W-1:0]            pen;
    logic [31:0]                 ib;
    logic [31:0]                 ia;
    logic [2:0][NRM_W-1:0]       n;
    logic [2:0][VEL_W-1:0]       vb;
    logic [2:0][VEL_W-1:0]       va;
  } in_t;

  typedef struct packed {
    logic [2:0][VEL_W-1:0]       va;
    logic [2:0][VEL_W-1:0]       vb;
    logic [2:0][NRM_W-1:0]       nm;
    logic [2:0]                  nneg;
    logic                        dneg;
    logic [VEL_W-1:0]            sep;
    logic [PEN_W-1:0]            pen;
    logic                        degen;
  } ctx_t;

  typedef struct packed {
    logic                        last;
    logic                        degen;
    logic [VEL_W-1:0]            sep;
    logic [2:0][VEL_W-1:0]       sh;
    logic [2:0][VEL_W-1:0]       nv;
    logic                        which;
  } res_t;

  function automatic logic [VEL_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic [VEL_W-1:0] r;
    if (x > 72'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -72'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[VEL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pcr_div.sv =====
// pcr_div: pipelined restoring divider, floor(num * 2^FRAC_BITS / den), one quotient bit a stage
// depends on nothing; num must not exceed den
module pcr_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          num,
  input  logic [32:0]          den,
  output logic [FRAC_BITS:0]   quo,
  output logic                 rem_nz
);

  localparam int STEPS = FRAC_BITS + 1;

  logic [33:0]        rem_r [STEPS];
  logic [32:0]        den_r [STEPS];
  logic [FRAC_BITS:0] quo_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [33:0]        rin;
    logic [32:0]        dn;
    logic [FRAC_BITS:0] qin;
    logic               ge;

    if (i == 0) begin : g_first
      assign rin = {2'b00, num};
      assign dn  = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = {rem_r[i-1][32:0], 1'b0};
      assign dn  = den_r[i-1];
      assign qin = quo_r[i-1];
    end

    assign ge = (rin >= {1'b0, dn});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? (rin - {1'b0, dn}) : rin;
        den_r[i] <= dn;
        quo_r[i] <= qin | ({{FRAC_BITS{1'b0}}, ge} << (FRAC_BITS - i));
      end
    end
  end

  assign quo    = quo_r[STEPS-1];
  assign rem_nz = (rem_r[STEPS-1] != '0);

endmodule

// ===== rtl/particle_contact_resolve.sv =====
// particle_contact_resolve: impulse based resolution of one two-particle contact per transaction
// depends on pcr_pkg and pcr_div
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata: contact (velocities, normal, inv masses, depth)
//  out_    | out | out_tvalid/tready  | out_tdata, out_tuser, out_tlast: one particle result
//  cfg_    | in  | cfg_we             | cfg_wdata: restitution, unsigned with FRAC_BITS fraction
//
// one contact enters per transaction and gives two result transactions, A then B
// the output register emits the two results in turn; a full last stage waits until B is taken
// most of the path from input transaction to the A result is the one-bit-per-stage weight divider
// rst_n clears the valid bits, the output valid and phase, and restitution; no clearing pass
// a stall on the output freezes the whole pipeline once its last stage is full, nothing is dropped or repeated
module particle_contact_resolve #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // vel_a_x/y/z, vel_b_x/y/z, normal_x/y/z, inv_mass_a, inv_mass_b, penetration_depth, zero pad
  input  logic [pcr_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // new_vel_x/y/z, shift_x/y/z, separating_speed
  output logic [pcr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // which_particle, degenerate
  output logic [pcr_pkg::OUT_TUSER_W-1:0]  out_tuser,
  // last_result
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [pcr_pkg::REST_W-1:0]       cfg_wdata
);
  import pcr_pkg::*;

  // widths that follow from the fraction length
  localparam int DMW  = MAG_W - FRAC_BITS;
  localparam int FACW = ((FRAC_BITS > REST_W) ? FRAC_BITS : REST_W) + 1;
  localparam int KW   = DMW + FACW - FRAC_BITS;
  localparam int WW   = FRAC_BITS + 1;
  localparam int DVW  = NRM_W + KW - FRAC_BITS;
  localparam int SHW  = NRM_W + PEN_W - FRAC_BITS;
  localparam int NVW  = ((DVW + 1 > VEL_W + 1) ? DVW + 1 : VEL_W + 1) + 1;
  localparam int DLY  = FRAC_BITS - 2;
  localparam int D    = FRAC_BITS + 2;
  localparam int LAST = D + 4;

  logic [REST_W-1:0] rest_r;
  logic [LAST:0]     vld_r;
  logic              adv;
  logic              out_take;

  // stage 0: captured transaction
  in_t s0_r;

  // stage 1: differences, magnitudes, mass sum
  ctx_t                  s1_ctx_r,  s1_ctx_nxt;
  logic [2:0][32:0]      s1_diff_r, s1_diff_nxt;
  logic [2:0][NRM_W-1:0] s1_n_r;
  logic [31:0]           s1_ia_r;
  logic [32:0]           s1_sum_r,  s1_sum_nxt;

  // stage 2: component products
  ctx_t                  s2_ctx_r;
  logic [2:0][DOT_W-1:0] s2_prod_r, s2_prod_nxt;

  // stage 3: separating speed
  ctx_t                  s3_ctx_r,  s3_ctx_nxt;
  logic [DMW-1:0]        s3_dm_r,   s3_dm_nxt;

  // stage 4: impulse magnitude
  ctx_t                  s4_ctx_r;
  logic [KW-1:0]         s4_k_r,    s4_k_nxt;

  // delay to meet the divider output
  ctx_t                  dly_ctx_r [DLY];
  logic [KW-1:0]         dly_k_r   [DLY];

  logic [WW-1:0]         div_wa;
  logic                  div_rnz;

  // stage E1: weights and particle A impulse
  ctx_t                  e1_ctx_r;
  logic [WW-1:0]         e1_wb_r,   e1_wb_nxt;
  logic [KW-1:0]         e1_ga_r,   e1_ga_nxt;
  logic [PEN_W-1:0]      e1_pa_r,   e1_pa_nxt;
  logic [KW-1:0]         e1_k_r;

  // stage E2: particle B impulse
  ctx_t                  e2_ctx_r;
  logic [KW-1:0]         e2_ga_r, e2_gb_r, e2_gb_nxt;
  logic [PEN_W-1:0]      e2_pa_r, e2_pb_r, e2_pb_nxt;

  // stage E3: per-component magnitudes
  ctx_t                  e3_ctx_r;
  logic [2:0][DVW-1:0]   e3_dva_r, e3_dvb_r, e3_dva_nxt, e3_dvb_nxt;
  logic [2:0][SHW-1:0]   e3_sha_r, e3_shb_r, e3_sha_nxt, e3_shb_nxt;

  // stage E4: signed, saturated results
  res_t                  e4_a_r, e4_b_r, e4_a_nxt, e4_b_nxt;

  // output register, A then B
  logic                  hold_v_r;
  logic                  phase_r;
  res_t                  hold_a_r, hold_b_r;
  res_t                  cur;

  // global advance: the last stage is empty or the output register frees up
  assign out_take  = !hold_v_r || (out_tready && phase_r);
  assign adv       = !vld_r[LAST] || out_take;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r   <= '0;
      vld_r    <= '0;
      hold_v_r <= 1'b0;
      phase_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        rest_r <= cfg_wdata;
      end
      if (adv) begin
        vld_r <= {vld_r[LAST-1:0], in_tvalid};
      end
      if (adv && vld_r[LAST]) begin
        hold_v_r <= 1'b1;
        phase_r  <= 1'b0;
      end else if (hold_v_r && out_tready) begin
        if (phase_r) begin
          hold_v_r <= 1'b0;
        end
        phase_r <= !phase_r;
      end
    end
  end

  // stage 1
  always_comb begin
    s1_ctx_nxt       = '0;
    s1_ctx_nxt.va    = s0_r.va;
    s1_ctx_nxt.vb    = s0_r.vb;
    s1_ctx_nxt.pen   = s0_r.pen;
    s1_ctx_nxt.degen = (s0_r.ia == '0) && (s0_r.ib == '0);
    for (int c = 0; c < 3; c++) begin
      s1_diff_nxt[c]     = 33'($signed(s0_r.va[c])) - 33'($signed(s0_r.vb[c]));
      s1_ctx_nxt.nneg[c] = s0_r.n[c][NRM_W-1];
      s1_ctx_nxt.nm[c]   = s0_r.n[c][NRM_W-1] ? NRM_W'(-s0_r.n[c]) : s0_r.n[c];
    end
    s1_sum_nxt = {1'b0, s0_r.ia} + {1'b0, s0_r.ib};
  end

  // stage 2
  always_comb begin
    logic signed [MAG_W-1:0] p [3];
    for (int c = 0; c < 3; c++) begin
      p[c]           = $signed(s1_diff_r[c]) * $signed(s1_n_r[c]);
      s2_prod_nxt[c] = DOT_W'(p[c]);
    end
  end

  // stage 3: dot product, magnitude truncated toward zero
  always_comb begin
    logic signed [DOT_W-1:0] dot;
    logic [DOT_W-1:0]        m;
    logic signed [DMW:0]     sv;
    dot        = $signed(s2_prod_r[0]) + $signed(s2_prod_r[1]) + $signed(s2_prod_r[2]);
    m          = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
    s3_dm_nxt  = m[MAG_W-1:FRAC_BITS];
    sv         = dot[DOT_W-1] ? -$signed({1'b0, s3_dm_nxt}) : $signed({1'b0, s3_dm_nxt});
    s3_ctx_nxt      = s2_ctx_r;
    s3_ctx_nxt.dneg = dot[DOT_W-1];
    s3_ctx_nxt.sep  = sat32(SAT_W'(sv));
  end

  // stage 4: K = |d| * (1 + e)
  always_comb begin
    logic [FACW-1:0]     fac;
    logic [DMW+FACW-1:0] kp;
    fac      = (FACW'(1) << FRAC_BITS) + FACW'(rest_r);
    kp       = s3_dm_r * fac;
    s4_k_nxt = kp[DMW+FACW-1:FRAC_BITS];
  end

  // E1: wb from the remainder, A impulse and shift scale
  always_comb begin
    logic [KW+WW-1:0]    gp;
    logic [PEN_W+WW-1:0] pp;
    e1_wb_nxt = (WW'(1) << FRAC_BITS) - div_wa - WW'(div_rnz);
    gp        = dly_k_r[DLY-1] * div_wa;
    pp        = dly_ctx_r[DLY-1].pen * div_wa;
    e1_ga_nxt = gp[KW+FRAC_BITS-1:FRAC_BITS];
    e1_pa_nxt = pp[PEN_W+FRAC_BITS-1:FRAC_BITS];
  end

  // E2: B impulse and shift scale
  always_comb begin
    logic [KW+WW-1:0]    gp;
    logic [PEN_W+WW-1:0] pp;
    gp        = e1_k_r * e1_wb_r;
    pp        = e1_ctx_r.pen * e1_wb_r;
    e2_gb_nxt = gp[KW+FRAC_BITS-1:FRAC_BITS];
    e2_pb_nxt = pp[PEN_W+FRAC_BITS-1:FRAC_BITS];
  end

  // E3: scale by each normal component
  always_comb begin
    logic [NRM_W+KW-1:0]    ta [3];
    logic [NRM_W+KW-1:0]    tb [3];
    logic [NRM_W+PEN_W-1:0] ua [3];
    logic [NRM_W+PEN_W-1:0] ub [3];
    for (int c = 0; c < 3; c++) begin
      ta[c] = e2_ctx_r.nm[c] * e2_ga_r;
      tb[c] = e2_ctx_r.nm[c] * e2_gb_r;
      ua[c] = e2_ctx_r.nm[c] * e2_pa_r;
      ub[c] = e2_ctx_r.nm[c] * e2_pb_r;
      e3_dva_nxt[c] = ta[c][NRM_W+KW-1:FRAC_BITS];
      e3_dvb_nxt[c] = tb[c][NRM_W+KW-1:FRAC_BITS];
      e3_sha_nxt[c] = ua[c][NRM_W+PEN_W-1:FRAC_BITS];
      e3_shb_nxt[c] = ub[c][NRM_W+PEN_W-1:FRAC_BITS];
    end
  end

  // E4: apply signs, update velocities, saturate
  always_comb begin
    logic signed [DVW:0] sda [3];
    logic signed [DVW:0] sdb [3];
    logic signed [SHW:0] ssa [3];
    logic signed [SHW:0] ssb [3];
    logic signed [NVW-1:0] nva [3];
    logic signed [NVW-1:0] nvb [3];
    logic flip;
    e4_a_nxt       = '0;
    e4_b_nxt       = '0;
    e4_a_nxt.which = PART_A;
    e4_b_nxt.which = PART_B;
    e4_a_nxt.last  = 1'b0;
    e4_b_nxt.last  = 1'b1;
    e4_a_nxt.sep   = e3_ctx_r.sep;
    e4_b_nxt.sep   = e3_ctx_r.sep;
    e4_a_nxt.degen = e3_ctx_r.degen;
    e4_b_nxt.degen = e3_ctx_r.degen;
    for (int c = 0; c < 3; c++) begin
      flip   = e3_ctx_r.dneg != e3_ctx_r.nneg[c];
      sda[c] = flip ? -$signed({1'b0, e3_dva_r[c]}) : $signed({1'b0, e3_dva_r[c]});
      sdb[c] = flip ? -$signed({1'b0, e3_dvb_r[c]}) : $signed({1'b0, e3_dvb_r[c]});
      ssa[c] = e3_ctx_r.nneg[c] ? -$signed({1'b0, e3_sha_r[c]}) : $signed({1'b0, e3_sha_r[c]});
      ssb[c] = e3_ctx_r.nneg[c] ? $signed({1'b0, e3_shb_r[c]}) : -$signed({1'b0, e3_shb_r[c]});
      nva[c] = NVW'($signed(e3_ctx_r.va[c])) - NVW'(sda[c]);
      nvb[c] = NVW'($signed(e3_ctx_r.vb[c])) + NVW'(sdb[c]);
      if (e3_ctx_r.degen) begin
        // both immovable: velocities pass through, no shift
        e4_a_nxt.nv[c] = e3_ctx_r.va[c];
        e4_b_nxt.nv[c] = e3_ctx_r.vb[c];
        e4_a_nxt.sh[c] = '0;
        e4_b_nxt.sh[c] = '0;
      end else begin
        e4_a_nxt.nv[c] = sat32(SAT_W'(nva[c]));
        e4_b_nxt.nv[c] = sat32(SAT_W'(nvb[c]));
        e4_a_nxt.sh[c] = sat32(SAT_W'(ssa[c]));
        e4_b_nxt.sh[c] = sat32(SAT_W'(ssb[c]));
      end
    end
  end

  // payload registers, all move together
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r      <= in_t'(in_tdata[$bits(in_t)-1:0]);
      s1_ctx_r  <= s1_ctx_nxt;
      s1_diff_r <= s1_diff_nxt;
      s1_n_r    <= s0_r.n;
      s1_ia_r   <= s0_r.ia;
      s1_sum_r  <= s1_sum_nxt;
      s2_ctx_r  <= s1_ctx_r;
      s2_prod_r <= s2_prod_nxt;
      s3_ctx_r  <= s3_ctx_nxt;
      s3_dm_r   <= s3_dm_nxt;
      s4_ctx_r  <= s3_ctx_r;
      s4_k_r    <= s4_k_nxt;
      dly_ctx_r[0] <= s4_ctx_r;
      dly_k_r[0]   <= s4_k_r;
      for (int k = 1; k < DLY; k++) begin
        dly_ctx_r[k] <= dly_ctx_r[k-1];
        dly_k_r[k]   <= dly_k_r[k-1];
      end
      e1_ctx_r  <= dly_ctx_r[DLY-1];
      e1_wb_r   <= e1_wb_nxt;
      e1_ga_r   <= e1_ga_nxt;
      e1_pa_r   <= e1_pa_nxt;
      e1_k_r    <= dly_k_r[DLY-1];
      e2_ctx_r  <= e1_ctx_r;
      e2_ga_r   <= e1_ga_r;
      e2_pa_r   <= e1_pa_r;
      e2_gb_r   <= e2_gb_nxt;
      e2_pb_r   <= e2_pb_nxt;
      e3_ctx_r  <= e2_ctx_r;
      e3_dva_r  <= e3_dva_nxt;
      e3_dvb_r  <= e3_dvb_nxt;
      e3_sha_r  <= e3_sha_nxt;
      e3_shb_r  <= e3_shb_nxt;
      e4_a_r    <= e4_a_nxt;
      e4_b_r    <= e4_b_nxt;
    end
    if (adv && vld_r[LAST]) begin
      hold_a_r <= e4_a_r;
      hold_b_r <= e4_b_r;
    end
  end

  // mass weight of A, ready at stage D
  pcr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .en     (adv),
    .num    (s1_ia_r),
    .den    (s1_sum_r),
    .quo    (div_wa),
    .rem_nz (div_rnz)
  );

  assign cur        = phase_r ? hold_b_r : hold_a_r;
  assign out_tvalid = hold_v_r;
  assign out_tdata  = {cur.sep, cur.sh, cur.nv};
  assign out_tuser  = {cur.degen, cur.which};
  assign out_tlast  = cur.last;

  // the B result always follows an accepted A result
  a_b_follows_a: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && out_tuser[0]))
    else $error("B result missing after A");

  // no new contact enters while A is still waiting with a full last stage
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && !phase_r && vld_r[LAST]) |-> !in_tready)
    else $error("pipeline advanced over a pending result");

  // a degenerate contact never shifts a particle
  a_degen_noshift: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata[191:96] == '0))
    else $error("degenerate contact with nonzero shift");

endmodule

// ===== bench/tb_particle_contact_resolve.sv =====
// tb_particle_contact_resolve: self-checking bench for the contact resolver, drives contacts
// on the input stream, predicts both particle results and checks them on the output stream
// depends on pcr_pkg and the particle_contact_resolve rtl
`timescale 1ns / 1ps

module tb_particle_contact_resolve;
  import pcr_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam longint unsigned MAG_LIMIT = 64'd1 << 62;

  // one contact as the bench sees it
  typedef struct {
    bit [31:0] vel_a [3];
    bit [31:0] vel_b [3];
    bit [17:0] nrm [3];
    bit [31:0] inv_a;
    bit [31:0] inv_b;
    bit [30:0] depth;
  } contact_t;

  // one particle result, field by field
  typedef struct packed {
    bit [2:0][31:0] new_vel;
    bit [2:0][31:0] shift;
    bit [31:0]      sep_speed;
    bit             which;
    bit             degen;
    bit             last;
  } particle_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_we;
  logic [REST_W-1:0] cfg_wdata;

  particle_res_t pending_res[$];
  bit [16:0] restitution_q;
  int        error_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        quiet_cycles;

  particle_contact_resolve #(.FRAC_BITS(FRAC)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // exact product shifted down by the fraction, magnitude capped
  function automatic longint unsigned mul_frac(longint unsigned a, longint unsigned b);
    bit [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> FRAC;
    return (p > {64'd0, MAG_LIMIT}) ? MAG_LIMIT : p[63:0];
  endfunction

  function automatic longint apply_sign(bit neg, longint unsigned m);
    longint unsigned c;
    c = (m > MAG_LIMIT) ? MAG_LIMIT : m;
    return neg ? -longint'(c) : longint'(c);
  endfunction

  function automatic bit [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // impulse and position correction for both particles, A result first
  task automatic predict_contact(input contact_t c);
    longint va [3], vb [3], nv [3];
    longint dot, sep;
    longint unsigned dmag, sum, kmag, wa, wb, ga, gb, pa, pb, nmag;
    bit dneg, nneg, degen;
    particle_res_t ra, rb;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      va[i] = longint'($signed(c.vel_a[i]));
      vb[i] = longint'($signed(c.vel_b[i]));
      nv[i] = longint'($signed(c.nrm[i]));
      dot += (va[i] - vb[i]) * nv[i];
    end
    dneg = dot < 0;
    dmag = (dneg ? -dot : dot) >> FRAC;
    sep = apply_sign(dneg, dmag);
    degen = (c.inv_a == 0) && (c.inv_b == 0);
    wa = 0; wb = 0; ga = 0; gb = 0; pa = 0; pb = 0;
    if (!degen) begin
      sum = longint'(c.inv_a) + longint'(c.inv_b);
      kmag = mul_frac(dmag, (64'd1 << FRAC) + restitution_q);
      wa = (longint'(c.inv_a) << FRAC) / sum;
      wb = (longint'(c.inv_b) << FRAC) / sum;
      ga = mul_frac(kmag, wa);
      gb = mul_frac(kmag, wb);
      pa = (longint'(c.depth) * wa) >> FRAC;
      pb = (longint'(c.depth) * wb) >> FRAC;
    end
    ra = '0;
    rb = '0;
    for (int i = 0; i < 3; i++) begin
      nmag = (nv[i] < 0) ? -nv[i] : nv[i];
      nneg = nv[i] < 0;
      if (degen) begin
        ra.new_vel[i] = clamp32(va[i]);
        rb.new_vel[i] = clamp32(vb[i]);
      end else begin
        ra.new_vel[i] = clamp32(va[i] - apply_sign(dneg != nneg, mul_frac(nmag, ga)));
        rb.new_vel[i] = clamp32(vb[i] + apply_sign(dneg != nneg, mul_frac(nmag, gb)));
        ra.shift[i] = clamp32(apply_sign(nneg, (nmag * pa) >> FRAC));
        // B is pushed the other way along the normal
        rb.shift[i] = clamp32(apply_sign(!nneg, (nmag * pb) >> FRAC));
      end
    end
    ra.sep_speed = clamp32(sep);
    rb.sep_speed = clamp32(sep);
    ra.which = PART_A;
    rb.which = PART_B;
    ra.degen = degen;
    rb.degen = degen;
    ra.last = 1'b0;
    rb.last = 1'b1;
    pending_res.push_back(ra);
    pending_res.push_back(rb);
  endtask

  // one contact transaction, expectations queued at acceptance
  task automatic send_contact(input contact_t c);
    logic [IN_TDATA_W-1:0] d;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    d = '0;
    for (int i = 0; i < 3; i++) begin
      d[32*i +: 32]      = c.vel_a[i];
      d[96 + 32*i +: 32] = c.vel_b[i];
      d[192 + 18*i +: 18] = c.nrm[i];
    end
    d[246 +: 32] = c.inv_a;
    d[278 +: 32] = c.inv_b;
    d[310 +: 31] = c.depth;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    predict_contact(c);
    @(negedge clk);
  endtask

  // wait for the pipe to drain, then write restitution
  task automatic set_restitution(input bit [16:0] value);
    in_tvalid <= 1'b0;
    while (pending_res.size() > 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    restitution_q = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [31:0] rand_vel();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1, 0) ? 32'h7fff_ffff - $urandom_range(255)
                                     : 32'h8000_0000 + $urandom_range(255);
      default: return 32'($signed($urandom_range(2 * 1048576)) - 1048576);
    endcase
  endfunction

  function automatic bit [31:0] rand_inv_mass();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hffff_ffff - $urandom_range(15);
      default: return $urandom_range(1 << 20, 1);
    endcase
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    for (int i = 0; i < 3; i++) begin
      c.vel_a[i] = rand_vel();
      c.vel_b[i] = rand_vel();
      // mostly within unit range, some raw 18-bit patterns
      c.nrm[i] = ($urandom_range(7) == 0) ? 18'($urandom())
                                           : 18'($signed($urandom_range(131072)) - 65536);
    end
    c.inv_a = rand_inv_mass();
    c.inv_b = rand_inv_mass();
    if ($urandom_range(15) == 0) begin
      c.inv_a = 0;
      c.inv_b = 0;
    end
    c.depth = ($urandom_range(1)) ? 31'($urandom()) : 31'($urandom_range(1 << 18));
    return c;
  endfunction

  function automatic contact_t make_contact(bit [31:0] va, bit [31:0] vb, bit [17:0] n,
                                            bit [31:0] ia, bit [31:0] ib, bit [30:0] dep);
    contact_t c;
    for (int i = 0; i < 3; i++) begin
      c.vel_a[i] = va;
      c.vel_b[i] = vb;
      c.nrm[i]   = n;
    end
    c.inv_a = ia;
    c.inv_b = ib;
    c.depth = dep;
    return c;
  endfunction

  task automatic test_directed();
    contact_t c;
    set_restitution(17'd0);
    // both masses zero: nothing moves, speed still reported
    send_contact(make_contact(32'h0001_0000, 32'hffff_0000, 18'h10000, 0, 0, 31'h100));
    send_contact(make_contact(0, 0, 0, 0, 0, 0));
    // one particle immovable
    send_contact(make_contact(32'h0002_0000, 0, 18'h10000, 32'h1_0000, 0, 31'h8000));
    send_contact(make_contact(32'h0002_0000, 0, 18'h30000, 0, 32'h1_0000, 31'h8000));
    // velocity and normal extremes, saturating results
    send_contact(make_contact(32'h7fff_ffff, 32'h8000_0000, 18'h1ffff, 32'hffff_ffff,
                              32'hffff_ffff, 31'h7fff_ffff));
    send_contact(make_contact(32'h8000_0000, 32'h7fff_ffff, 18'h20000, 32'hffff_ffff, 1,
                              31'h7fff_ffff));
    send_contact(make_contact(32'h8000_0000, 32'h7fff_ffff, 18'h1ffff, 1, 32'hffff_ffff,
                              31'h7fff_ffff));
    // normal beyond unit length used as given
    send_contact(make_contact(32'h0010_0000, 32'hfff0_0000, 18'h1ffff, 32'h1_0000, 32'h1_0000,
                              31'h1_0000));
    c = make_contact(32'h0003_0000, 32'h0001_0000, 18'h0, 32'h8000, 32'h1_8000, 31'h2_0000);
    c.nrm[0] = 18'h10000;
    send_contact(c);
    set_restitution(17'h1_0000);
    send_contact(make_contact(32'h7fff_ffff, 32'h8000_0000, 18'h20000, 32'h1234, 32'h5678,
                              31'h7fff_ffff));
    send_contact(make_contact(32'h0001_0000, 32'h0004_0000, 18'h3_0000, 32'h2_0000,
                              32'h1_0000, 31'h4_0000));
    set_restitution(17'h1_ffff);
    send_contact(make_contact(32'h7fff_ffff, 32'h8000_0000, 18'h1ffff, 32'hffff_ffff,
                              32'hffff_ffff, 31'h7fff_ffff));
    send_contact(make_contact(32'h0005_0000, 32'h0, 18'h10000, 32'h1, 32'h1, 31'h1));
  endtask

  task automatic run_random(input int items, input int idle_pct, input int stall_pct,
                            input bit [16:0] rest);
    set_restitution(rest);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      send_contact(rand_contact());
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic test_random_no_idle();
    run_random(500, 0, 0, 17'($urandom_range(65536)));
  endtask

  task automatic test_sender_idle();
    run_random(450, 87, 0, 17'h1_0000);
  endtask

  task automatic test_receiver_stall();
    run_random(450, 0, 87, 17'($urandom()));
  endtask

  task automatic test_both_idle();
    run_random(500, 6, 6, 17'd0);
  endtask

  // receiver readiness changes on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    particle_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      for (int i = 0; i < 3; i++) begin
        got.new_vel[i] = out_tdata[32*i +: 32];
        got.shift[i]   = out_tdata[96 + 32*i +: 32];
      end
      got.sep_speed = out_tdata[192 +: 32];
      got.which = out_tuser[0];
      got.degen = out_tuser[1];
      got.last  = out_tlast;
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result transaction: actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_res.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.new_vel[i] !== want.new_vel[i]) begin
            $display("%0t new_vel[%0d] expected %h actual %h", $time, i,
                     want.new_vel[i], got.new_vel[i]);
            error_count++;
          end
          if (got.shift[i] !== want.shift[i]) begin
            $display("%0t shift[%0d] expected %h actual %h", $time, i,
                     want.shift[i], got.shift[i]);
            error_count++;
          end
        end
        if (got.sep_speed !== want.sep_speed) begin
          $display("%0t separating_speed expected %h actual %h", $time,
                   want.sep_speed, got.sep_speed);
          error_count++;
        end
        if ({got.which, got.degen, got.last} !== {want.which, want.degen, want.last}) begin
          $display("%0t which/degenerate/last expected %b actual %b", $time,
                   {want.which, want.degen, want.last}, {got.which, got.degen, got.last});
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL particle_contact_resolve");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    restitution_q  = '0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    recv_stall_pct = 0;
    while (pending_res.size() > 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS particle_contact_resolve");
    end else begin
      $display("FAIL particle_contact_resolve");
    end
    $finish;
  end

endmodule

// ===== particle_contact_resolve.f =====
rtl/pcr_pkg.sv
rtl/pcr_div.sv
rtl/particle_contact_resolve.sv
bench/tb_particle_contact_resolve.sv
